// ----- design/linm_pkg.sv -----
// Shared types, codes and helper functions of the LIN master frame engine.
package linm_pkg;

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BUSY = 2'd2;

    // Header bytes
    localparam logic [7:0] HDR_BREAK  = 8'h00;
    localparam logic [7:0] HDR_DELIM  = 8'h80;
    localparam logic [7:0] HDR_SYNC   = 8'h55;
    localparam logic [7:0] SUM_TARGET = 8'hFF;

    // Header beat positions
    localparam logic [1:0] BEAT_BREAK = 2'd0;
    localparam logic [1:0] BEAT_DELIM = 2'd1;
    localparam logic [1:0] BEAT_SYNC  = 2'd2;
    localparam logic [1:0] BEAT_PID   = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [5:0] frame_id;
        logic [7:0] rx_byte;
    } linm_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       checksum_ok;
        logic       last;
    } linm_out_t;

    // Work handed to the output serializer
    typedef enum logic [1:0] {
        JOB_HDR,
        JOB_BUSY,
        JOB_DONE
    } linm_job_kind_t;

    typedef struct packed {
        linm_job_kind_t kind;
        logic [7:0]     pid;
        logic           ok;
    } linm_job_t;

    // Protected identifier: id with parity bits P0 and P1 on top
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Response data length selected by identifier bits 5:4
    function automatic logic [3:0] data_len(input logic [1:0] sel);
        logic [3:0] len;
        case (sel)
            2'd0:    len = 4'd2;
            2'd1:    len = 4'd2;
            2'd2:    len = 4'd4;
            default: len = 4'd8;
        endcase
        return len;
    endfunction

endpackage

// ----- design/lin_master_frame_engine_core.sv -----
// LIN master frame engine: frame state tracking, checksum check and result output.
// The job of an accepted request is registered in the job buffer and then in the
// serializer before its first result is shown. A start request gives four result beats
// (four header bytes), or one busy beat; a byte that ends a frame gives one frame-complete beat.
// A two-entry job path (buffer plus serializer) lets requests enter while results wait.
// Reset (aresetn, synchronous, active low) returns to idle with no results pending.
module lin_master_frame_engine_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  linm_pkg::linm_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output linm_pkg::linm_out_t m_data
);
    import linm_pkg::*;

    logic       receiving_reg, receiving_next;
    logic [3:0] expected_count_reg, expected_count_next;
    logic [3:0] received_count_reg, received_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       accept;
    logic       push;
    linm_job_t  push_job;
    logic [7:0] sum_add;

    assign accept  = s_valid && s_ready;
    assign sum_add = running_sum_reg + s_data.rx_byte;

    // Update frame state and build the job for each request
    always_comb begin
        receiving_next      = receiving_reg;
        expected_count_next = expected_count_reg;
        received_count_next = received_count_reg;
        running_sum_next    = running_sum_reg;
        push                = 1'b0;
        push_job.kind       = JOB_HDR;
        push_job.pid        = protect_id(s_data.frame_id);
        push_job.ok         = (sum_add == SUM_TARGET);
        if (accept) begin
            if (s_data.opcode == OP_START) begin
                push = 1'b1;
                if (receiving_reg) begin
                    push_job.kind = JOB_BUSY;
                end else begin
                    expected_count_next = data_len(s_data.frame_id[5:4]);
                    received_count_next = '0;
                    running_sum_next    = '0;
                    receiving_next      = 1'b1;
                end
            end else if (receiving_reg) begin
                if (received_count_reg < expected_count_reg) begin
                    running_sum_next    = sum_add;
                    received_count_next = received_count_reg + 4'd1;
                end else begin
                    push                = 1'b1;
                    push_job.kind       = JOB_DONE;
                    receiving_next      = 1'b0;
                    received_count_next = '0;
                    running_sum_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg      <= 1'b0;
            expected_count_reg <= '0;
            received_count_reg <= '0;
            running_sum_reg    <= '0;
        end else begin
            receiving_reg      <= receiving_next;
            expected_count_reg <= expected_count_next;
            received_count_reg <= received_count_next;
            running_sum_reg    <= running_sum_next;
        end
    end

    linm_out_ser u_out_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // Received count never passes the expected count
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        received_count_reg <= expected_count_reg)
        else $error("received count beyond expected count");

    // An accepted start while idle opens a frame
    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.opcode == OP_START && !receiving_reg) |=> receiving_reg)
        else $error("start did not open a frame");

    // A frame in progress always has a legal data length
    a_len_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        receiving_reg |-> (expected_count_reg == 4'd2 || expected_count_reg == 4'd4
                           || expected_count_reg == 4'd8))
        else $error("illegal expected count");

endmodule

// ----- design/linm_out_ser.sv -----
// Job buffer and result serializer: spreads one job into its result beats.
module linm_out_ser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  linm_pkg::linm_job_t push_job,
    output logic              push_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output linm_pkg::linm_out_t m_data
);
    import linm_pkg::*;

    logic       a_valid_reg, a_valid_next;
    linm_job_t  a_job_reg, a_job_next;
    logic       b_valid_reg, b_valid_next;
    linm_job_t  b_job_reg, b_job_next;
    logic [1:0] beat_reg, beat_next;
    logic       b_done;
    logic       b_free;
    logic       move;

    // Build the result beat shown on the output
    always_comb begin
        m_data = '0;
        case (b_job_reg.kind)
            JOB_HDR: begin
                m_data.kind = KIND_TX;
                case (beat_reg)
                    BEAT_BREAK: m_data.tx_byte = HDR_BREAK;
                    BEAT_DELIM: m_data.tx_byte = HDR_DELIM;
                    BEAT_SYNC:  m_data.tx_byte = HDR_SYNC;
                    default:    m_data.tx_byte = b_job_reg.pid;
                endcase
                m_data.last = (beat_reg == BEAT_PID);
            end
            JOB_BUSY: begin
                m_data.kind = KIND_BUSY;
                m_data.last = 1'b1;
            end
            JOB_DONE: begin
                m_data.kind        = KIND_DONE;
                m_data.checksum_ok = b_job_reg.ok;
                m_data.last        = 1'b1;
            end
            default: m_data = '0;
        endcase
    end

    assign m_valid    = b_valid_reg;
    assign b_done     = b_valid_reg && m_ready && m_data.last;
    assign b_free     = !b_valid_reg || b_done;
    assign move       = a_valid_reg && b_free;
    assign push_ready = !a_valid_reg || b_free;

    // Advance the buffer and the serializer
    always_comb begin
        a_valid_next = a_valid_reg;
        a_job_next   = a_job_reg;
        b_valid_next = b_valid_reg;
        b_job_next   = b_job_reg;
        beat_next    = beat_reg;
        if (move) begin
            a_valid_next = 1'b0;
        end
        if (push) begin
            a_valid_next = 1'b1;
            a_job_next   = push_job;
        end
        if (move) begin
            b_valid_next = 1'b1;
            b_job_next   = a_job_reg;
            beat_next    = BEAT_BREAK;
        end else if (b_done) begin
            b_valid_next = 1'b0;
        end else if (b_valid_reg && m_ready) begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            beat_reg    <= BEAT_BREAK;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            beat_reg    <= beat_next;
        end
        a_job_reg <= a_job_next;
        b_job_reg <= b_job_next;
    end

endmodule
